>>> hw/rtl/tpq_pkg.sv
package tpq_pkg;

  // default sizes
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned PriorityBits = 16;

  // width of the reported count and position fields
  localparam int unsigned CountW = 5;

  // operation codes carried on kind_i
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // what one cell shows its neighbors
  typedef struct packed {
    logic valid;
    logic tag;
    logic keep;
  } link_t;

endpackage

>>> hw/rtl/tpq_cell.sv
module tpq_cell #(
  parameter int unsigned PRIORITY_BITS = tpq_pkg::PriorityBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tpq_pkg::op_e             op_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic                     new_tag_i,
  input  tpq_pkg::link_t           left_i,
  input  logic [PRIORITY_BITS-1:0] left_prio_i,
  input  tpq_pkg::link_t           right_i,
  input  logic [PRIORITY_BITS-1:0] right_prio_i,
  output tpq_pkg::link_t           self_o,
  output logic [PRIORITY_BITS-1:0] prio_o
);
  import tpq_pkg::*;

  logic                     valid_q, valid_d;
  logic                     tag_q, tag_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                     keep;

  // entry stays put on a push when it ranks at or above the new one
  assign keep = valid_q && ($signed(prio_q) >= $signed(new_prio_i));

  // next value: hold, take the new entry, or shift from a neighbor
  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    prio_d  = prio_q;
    unique case (op_i)
      OP_PUSH: begin
        if (!keep) begin
          if (left_i.keep) begin
            valid_d = 1'b1;
            tag_d   = new_tag_i;
            prio_d  = new_prio_i;
          end else begin
            valid_d = left_i.valid;
            tag_d   = left_i.tag;
            prio_d  = left_prio_i;
          end
        end
      end
      OP_POP: begin
        valid_d = right_i.valid;
        tag_d   = right_i.tag;
        prio_d  = right_prio_i;
      end
      OP_CLEAR: begin
        valid_d = 1'b0;
        tag_d   = 1'b0;
      end
      default: ;
    endcase
  end

  // occupancy and tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tag_q   <= tag_d;
    end
  end

  // priority payload
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
  end

  assign self_o = '{valid: valid_q, tag: tag_q, keep: keep};
  assign prio_o = prio_q;

endmodule

>>> hw/rtl/tpq_status.sv
module tpq_status #(
  parameter int unsigned QUEUE_DEPTH   = tpq_pkg::QueueDepth,
  parameter int unsigned PRIORITY_BITS = tpq_pkg::PriorityBits,
  localparam int unsigned PosW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic [QUEUE_DEPTH-1:0]       tag_vec_i,
  input  logic                         head_valid_i,
  input  logic [PRIORITY_BITS-1:0]     head_prio_i,
  input  logic [PosW-1:0]              count_i,
  output logic [PRIORITY_BITS-1:0]     head_priority_o,
  output logic                         is_empty_o,
  output logic [tpq_pkg::CountW-1:0]   entry_count_o,
  output logic [tpq_pkg::CountW-1:0]   tagged_position_o
);
  import tpq_pkg::*;

  logic [PosW-1:0]        tag_pos;
  logic [CountW+PosW-1:0] count_wide;
  logic [CountW+PosW-1:0] pos_wide;

  // first tagged cell from the head; empty cells never hold a tag
  always_comb begin
    tag_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (tag_vec_i[i]) tag_pos = PosW'(i + 1);
    end
  end

  // head and fill reporting, counts masked to the field width
  assign head_priority_o   = head_valid_i ? head_prio_i : '0;
  assign is_empty_o        = (count_i == '0);
  assign count_wide        = {{CountW{1'b0}}, count_i};
  assign pos_wide          = {{CountW{1'b0}}, tag_pos};
  assign entry_count_o     = count_wide[CountW-1:0];
  assign tagged_position_o = pos_wide[CountW-1:0];

endmodule

>>> hw/rtl/tagged_priority_queue_core.sv
// Sorted priority queue built as a chain of QUEUE_DEPTH cells, the head in cell 0.
// A command (push, pop head, clear) is taken whenever start is high; busy
// stays low, so one command can be issued every clock cycle. All cells update
// together at the accepting edge and the status beat follows in the next cycle
// on valid_o, read straight from the cell registers, at one command per cycle.
// The receiver cannot stall, so every status beat must be captured in the
// cycle it appears. Equal priorities keep arrival order, a push into a full
// queue is dropped and flagged, counts wrap to 5 bits.
module tagged_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = tpq_pkg::QueueDepth,
  parameter int unsigned PRIORITY_BITS = tpq_pkg::PriorityBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [PRIORITY_BITS-1:0]   priority_req_i,
  input  logic                       tagged_req_i,
  output logic                       valid_o,
  output logic [PRIORITY_BITS-1:0]   head_priority_o,
  output logic                       is_empty_o,
  output logic [tpq_pkg::CountW-1:0] entry_count_o,
  output logic [tpq_pkg::CountW-1:0] tagged_position_o,
  output logic                       dropped_o
);
  import tpq_pkg::*;

  localparam int unsigned PosW = $clog2(QUEUE_DEPTH + 1);

  op_e                      op_in;
  op_e                      cell_op;
  logic                     accept;
  logic                     full;
  logic [PosW-1:0]          count_q, count_d;
  logic                     valid_q;
  logic                     dropped_q;

  link_t                    self_lnk [QUEUE_DEPTH];
  link_t                    left_lnk [QUEUE_DEPTH];
  link_t                    right_lnk [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_arr [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] left_prio [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] right_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   valid_vec;
  logic [QUEUE_DEPTH-1:0]   tag_vec;

  // command decode; a push into a full queue leaves the cells alone
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign op_in   = op_e'(kind_i);
  assign full    = (count_q == PosW'(QUEUE_DEPTH));
  assign cell_op = (!accept || (op_in == OP_PUSH && full)) ? OP_NOP : op_in;

  // fill counter
  always_comb begin
    count_d = count_q;
    unique case (cell_op)
      OP_PUSH:  count_d = count_q + PosW'(1);
      OP_POP:   if (count_q != '0) count_d = count_q - PosW'(1);
      OP_CLEAR: count_d = '0;
      default:  ;
    endcase
  end

  // control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      valid_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      valid_q   <= accept;
      dropped_q <= accept && (op_in == OP_PUSH) && full;
    end
  end

  // cell chain with neighbor links
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_lnk[i]  = '{valid: 1'b0, tag: 1'b0, keep: 1'b1};
      assign left_prio[i] = '0;
    end else begin : g_mid
      assign left_lnk[i]  = self_lnk[i-1];
      assign left_prio[i] = prio_arr[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_lnk[i]  = '{valid: 1'b0, tag: 1'b0, keep: 1'b0};
      assign right_prio[i] = '0;
    end else begin : g_body
      assign right_lnk[i]  = self_lnk[i+1];
      assign right_prio[i] = prio_arr[i+1];
    end

    tpq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .new_prio_i  (priority_req_i),
      .new_tag_i   (tagged_req_i),
      .left_i      (left_lnk[i]),
      .left_prio_i (left_prio[i]),
      .right_i     (right_lnk[i]),
      .right_prio_i(right_prio[i]),
      .self_o      (self_lnk[i]),
      .prio_o      (prio_arr[i])
    );

    assign valid_vec[i] = self_lnk[i].valid;
    assign tag_vec[i]   = self_lnk[i].tag;
  end

  // status beat
  tpq_status #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_status (
    .tag_vec_i        (tag_vec),
    .head_valid_i     (valid_vec[0]),
    .head_prio_i      (prio_arr[0]),
    .count_i          (count_q),
    .head_priority_o  (head_priority_o),
    .is_empty_o       (is_empty_o),
    .entry_count_o    (entry_count_o),
    .tagged_position_o(tagged_position_o)
  );

  assign valid_o   = valid_q;
  assign dropped_o = dropped_q;

  // fill counter tracks the occupied cells
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("fill count differs from occupied cells");

  // occupied cells form a prefix from the head
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells are not contiguous from the head");

  // empty cells never carry a tag
  a_tag_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_vec & ~valid_vec) == '0)
    else $error("tag set in an empty cell");

  // a dropped push leaves a full queue
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && dropped_o |-> full)
    else $error("push dropped while queue not full");

  // every accepted command yields one status beat next cycle
  a_beat_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("missing status beat");

endmodule
